// ===== rtl/core/btmx_pkg.sv =====
// constants and types shared by the max-xor trie block and its testbench
// no dependencies
`default_nettype none

package btmx_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int KEY_WIDTH  = 64;
  localparam int FIELD_W    = 64;

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;
  localparam int CMP_W  = (LVL_W > CNT_W) ? LVL_W : CNT_W;
  localparam int LINK_W = 2 * IDX_W;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [KEY_WIDTH-1:0] key_t;

  // both child links of one node, side one in the upper half
  typedef struct packed {
    idx_t one;
    idx_t zero;
  } links_t;

  function automatic idx_t link_side(links_t l, logic side);
    return side ? l.one : l.zero;
  endfunction

  function automatic links_t set_side(links_t l, logic side, idx_t c);
    links_t r;
    r = l;
    if (side) begin
      r.one = c;
    end else begin
      r.zero = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/btmx_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/binary_trie_max_xor_search.sv =====
// binary trie of keys with max-xor query, nodes held in btmx_ram
// depends on btmx_pkg and btmx_ram
// a query or insert walks the trie from the root, one level per node ram read; an insert
// that adds nodes then links one fresh node per remaining level in S_ALLOC and clears
// the leaf in S_LEAF; empty-set queries and rejected inserts finish early; S_FINISH loads
// the result, stalling until the previous one is taken; a new item enters only in idle,
// after S_FINISH, even while the previous result still waits in the output register
// reset: synchronous, clears control, root links and node count; node ram is not cleared
`default_nettype none

module binary_trie_max_xor_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic        action,
  input  wire logic [63:0] key,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [63:0]      best_partner,
  output logic [63:0]      max_xor,
  output logic             set_empty,
  output logic             insert_rejected
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_ALLOC  = 3'd2;
  localparam logic [2:0] S_LEAF   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]         state;
  logic               op;
  btmx_pkg::key_t     key_q;
  btmx_pkg::key_t     partner;
  btmx_pkg::idx_t     cur;
  btmx_pkg::links_t   cur_links;
  btmx_pkg::lvl_t     lvl;
  btmx_pkg::links_t   root_links;
  btmx_pkg::cnt_t     nodes_used;
  logic               reject;
  logic               empty;

  logic               wr_en;
  btmx_pkg::idx_t     wr_addr;
  btmx_pkg::links_t   wr_data;
  btmx_pkg::idx_t     rd_addr;
  btmx_pkg::links_t   rd_data;

  btmx_pkg::links_t   links;
  logic               kbit;
  logic               want;
  logic               took;
  btmx_pkg::idx_t     nx_ins;
  btmx_pkg::idx_t     nx_want;
  btmx_pkg::idx_t     nx_qry;
  btmx_pkg::cnt_t     free_nodes;
  logic               no_fit;
  btmx_pkg::idx_t     fresh;

  btmx_ram #(
    .WIDTH (btmx_pkg::LINK_W),
    .DEPTH (btmx_pkg::NODE_COUNT)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_ready = (state == S_IDLE);

  // index zero is the root, kept in flops; any other node comes from the ram
  assign links      = (cur == '0) ? root_links : rd_data;
  assign kbit       = key_q[lvl];
  assign want       = ~kbit;
  assign nx_ins     = btmx_pkg::link_side(links, kbit);
  assign nx_want    = btmx_pkg::link_side(links, want);
  assign took       = (nx_want != '0) ? want : kbit;
  assign nx_qry     = btmx_pkg::link_side(links, took);
  assign free_nodes = btmx_pkg::cnt_t'(btmx_pkg::NODE_COUNT) - nodes_used;
  // missing nodes (lvl + 1) exceed the free count
  assign no_fit     = btmx_pkg::CMP_W'(lvl) >= btmx_pkg::CMP_W'(free_nodes);
  assign fresh      = nodes_used[btmx_pkg::IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = '0;
    rd_addr = (op == btmx_pkg::ACT_QUERY) ? nx_qry : nx_ins;
    unique case (state)
      S_ALLOC: begin
        wr_en   = (cur != '0);
        wr_data = btmx_pkg::set_side(cur_links, kbit, fresh);
      end
      S_LEAF: begin
        wr_en   = 1'b1;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      root_links <= '0;
      nodes_used <= btmx_pkg::cnt_t'(1);
    end else begin
      // the finish state loads its own valid
      if (res_valid && res_ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op      <= action;
            key_q   <= key[btmx_pkg::KEY_WIDTH-1:0];
            cur     <= '0;
            lvl     <= btmx_pkg::lvl_t'(btmx_pkg::KEY_WIDTH - 1);
            partner <= '0;
            reject  <= 1'b0;
            if (action == btmx_pkg::ACT_QUERY && root_links == '0) begin
              empty <= 1'b1;
              state <= S_FINISH;
            end else begin
              empty <= 1'b0;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (op == btmx_pkg::ACT_QUERY) begin
            if (nx_qry == '0) begin
              state <= S_FINISH;
            end else begin
              partner <= (partner << 1) | btmx_pkg::key_t'(took);
              cur     <= nx_qry;
              if (lvl == '0) begin
                state <= S_FINISH;
              end else begin
                lvl <= lvl - 1'b1;
              end
            end
          end else if (nx_ins != '0) begin
            cur <= nx_ins;
            if (lvl == '0) begin
              state <= S_FINISH;
            end else begin
              lvl <= lvl - 1'b1;
            end
          end else if (no_fit) begin
            reject <= 1'b1;
            state  <= S_FINISH;
          end else begin
            cur_links <= links;
            state     <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          // link the fresh node under cur, then descend into it
          if (cur == '0) begin
            root_links <= btmx_pkg::set_side(root_links, kbit, fresh);
          end
          cur        <= fresh;
          cur_links  <= '0;
          nodes_used <= nodes_used + 1'b1;
          if (lvl == '0) begin
            state <= S_LEAF;
          end else begin
            lvl <= lvl - 1'b1;
          end
        end
        S_LEAF: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!res_valid || res_ready) begin
            res_valid       <= 1'b1;
            best_partner    <= 64'(partner);
            max_xor         <= (op == btmx_pkg::ACT_QUERY && !empty) ?
                               64'(key_q ^ partner) : '0;
            set_empty       <= empty;
            insert_rejected <= reject;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used != '0 && nodes_used <= btmx_pkg::cnt_t'(btmx_pkg::NODE_COUNT))
    else $error("node count out of range");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> nodes_used < btmx_pkg::cnt_t'(btmx_pkg::NODE_COUNT))
    else $error("allocation past the node memory");

  a_no_null_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_addr != '0)
    else $error("write to the null node");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && op == btmx_pkg::ACT_INSERT && nx_ins == '0 && no_fit
    |=> $stable(nodes_used) && reject)
    else $error("rejected insert changed the node count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(set_empty && insert_rejected))
    else $error("empty and rejected flags both set");

endmodule

`default_nettype wire

// ===== tb/sv/trie_answer_checker.sv =====
`timescale 1ns / 100ps
// checker for the max-xor trie: watches both channels, keeps its own trie copy
// and compares every result item against the prediction; depends on btmx_pkg

module trie_answer_checker
  import btmx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  logic        action,
  input  logic [63:0] key,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [63:0] best_partner,
  input  logic [63:0] max_xor,
  input  logic        set_empty,
  input  logic        insert_rejected,
  output int          error_count,
  output int          pending
);

  typedef struct packed {
    key_t partner;
    key_t xor_val;
    logic empty;
    logic rejected;
  } answer_t;

  // entry zero holds the root links, so index zero never gets allocated
  links_t  node_links[NODE_COUNT];
  int      nodes_taken;
  answer_t trie_answers[$];
  int      result_num;

  function automatic idx_t child_at(int n, logic side);
    return side ? node_links[n].one : node_links[n].zero;
  endfunction

  function automatic answer_t trie_insert(key_t k);
    answer_t a;
    int      cur;
    int      missing;
    int      fresh;
    idx_t    nx;
    a       = '0;
    cur     = 0;
    missing = 0;
    for (int lvl = KEY_WIDTH - 1; lvl >= 0; lvl--) begin
      nx = child_at(cur, k[lvl]);
      if (nx == '0) begin
        missing = lvl + 1;
        break;
      end
      cur = int'(nx);
    end
    if (missing == 0) begin
      return a;
    end
    if (missing > NODE_COUNT - nodes_taken) begin
      a.rejected = 1'b1;
      return a;
    end
    for (int lvl = missing - 1; lvl >= 0; lvl--) begin
      fresh = nodes_taken;
      nodes_taken++;
      node_links[fresh] = '0;
      if (k[lvl]) begin
        node_links[cur].one = idx_t'(fresh);
      end else begin
        node_links[cur].zero = idx_t'(fresh);
      end
      cur = fresh;
    end
    return a;
  endfunction

  function automatic answer_t trie_query(key_t k);
    answer_t a;
    int      cur;
    logic    side;
    idx_t    nx;
    a   = '0;
    cur = 0;
    if (node_links[0] == '0) begin
      a.empty = 1'b1;
      return a;
    end
    for (int lvl = KEY_WIDTH - 1; lvl >= 0; lvl--) begin
      // prefer the branch opposite to the query bit
      side = ~k[lvl];
      nx   = child_at(cur, side);
      if (nx == '0) begin
        side = ~side;
        nx   = child_at(cur, side);
      end
      a.partner[lvl] = side;
      cur = int'(nx);
    end
    a.xor_val = k ^ a.partner;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: result %0d %s mismatch: got %h, want %h",
             $realtime, result_num, what, got, want);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    pending     = 0;
    result_num  = 0;
    nodes_taken = 1;
    node_links[0] = '0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      node_links[0] = '0;
      nodes_taken   = 1;
      trie_answers.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (trie_answers.size() == 0) begin
          $display("%0t: result %0d arrived with no item outstanding",
                   $realtime, result_num);
          error_count++;
        end else begin
          want = trie_answers.pop_front();
          if (best_partner !== want.partner) begin
            report_mismatch("best_partner", best_partner, want.partner);
          end
          if (max_xor !== want.xor_val) begin
            report_mismatch("max_xor", max_xor, want.xor_val);
          end
          if (set_empty !== want.empty) begin
            report_mismatch("set_empty", 64'(set_empty), 64'(want.empty));
          end
          if (insert_rejected !== want.rejected) begin
            report_mismatch("insert_rejected", 64'(insert_rejected), 64'(want.rejected));
          end
        end
        result_num++;
      end
      if (cmd_valid && cmd_ready) begin
        if (action == ACT_QUERY) begin
          trie_answers.push_back(trie_query(key));
        end else begin
          trie_answers.push_back(trie_insert(key));
        end
      end
    end
    pending = trie_answers.size();
  end

endmodule

// ===== tb/sv/tb_binary_trie_max_xor_search.sv =====
`timescale 1ns / 100ps
// top of the max-xor trie testbench: clock, reset, item stimulus and verdict
// depends on btmx_pkg, binary_trie_max_xor_search and trie_answer_checker

module tb_binary_trie_max_xor_search;
  import btmx_pkg::*;

  localparam int PHASE_ITEMS = 367;
  localparam int QUIET_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  logic        action;
  logic [63:0] key;
  logic        res_valid;
  logic        res_ready;
  logic [63:0] best_partner;
  logic [63:0] max_xor;
  logic        set_empty;
  logic        insert_rejected;
  int          error_count;
  int          pending;

  int   tx_idle_pct;
  int   rx_idle_pct;
  int   quiet_cycles;
  key_t inserted_keys[$];

  binary_trie_max_xor_search u_top (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .action          (action),
    .key             (key),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .best_partner    (best_partner),
    .max_xor         (max_xor),
    .set_empty       (set_empty),
    .insert_rejected (insert_rejected)
  );

  trie_answer_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .action          (action),
    .key             (key),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .best_partner    (best_partner),
    .max_xor         (max_xor),
    .set_empty       (set_empty),
    .insert_rejected (insert_rejected),
    .error_count     (error_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  always @(negedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // nothing accepted on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and returns at a falling edge; valid stays up between back-to-back items
  task automatic send_item(input logic act, input key_t k);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    action    = act;
    key       = k;
    if (act == ACT_INSERT) begin
      inserted_keys.push_back(k);
    end
    @(posedge clk);
    while (!cmd_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic key_t any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic key_t stored_key();
    if (inserted_keys.size() == 0) begin
      return any_key();
    end
    return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
  endfunction

  // flip a random tail of a stored key; short tails still fit once the ram is nearly full
  function automatic key_t near_key();
    int   top_bit;
    key_t flip;
    top_bit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
    flip    = (key_t'(1) << top_bit) | (any_key() & ((key_t'(1) << top_bit) - 1));
    return stored_key() ^ flip;
  endfunction

  function automatic key_t odd_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return key_t'(1) << $urandom_range(0, 63);
      default: return ~(key_t'(1) << $urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      send_item(ACT_INSERT, any_key());
    end else if (sel < 42) begin
      send_item(ACT_INSERT, near_key());
    end else if (sel < 50) begin
      send_item(ACT_INSERT, stored_key());
    end else if (sel < 55) begin
      send_item(ACT_INSERT, odd_key());
    end else if (sel < 70) begin
      send_item(ACT_QUERY, any_key());
    end else if (sel < 80) begin
      send_item(ACT_QUERY, ~stored_key());
    end else if (sel < 88) begin
      send_item(ACT_QUERY, near_key());
    end else if (sel < 94) begin
      send_item(ACT_QUERY, stored_key());
    end else begin
      send_item(ACT_QUERY, odd_key());
    end
  endtask

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    action       = ACT_INSERT;
    key          = '0;
    res_ready    = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct  = 27;
    rx_idle_pct  = 51;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty set, extremes, duplicates and one-node inserts
    send_item(ACT_QUERY,  '0);
    send_item(ACT_QUERY,  '1);
    send_item(ACT_INSERT, '0);
    send_item(ACT_QUERY,  '0);
    send_item(ACT_QUERY,  '1);
    send_item(ACT_INSERT, '1);
    send_item(ACT_INSERT, '1);
    send_item(ACT_QUERY,  64'h0f0f_0f0f_0f0f_0f0f);
    send_item(ACT_INSERT, 64'h8000_0000_0000_0001);
    send_item(ACT_INSERT, 64'h0000_0000_0000_0001);
    send_item(ACT_QUERY,  64'h8000_0000_0000_0000);
    send_item(ACT_QUERY,  64'h7fff_ffff_ffff_ffff);
    send_item(ACT_INSERT, 64'h5555_5555_5555_5555);
    send_item(ACT_QUERY,  64'haaaa_aaaa_aaaa_aaaa);
    send_item(ACT_QUERY,  64'h5555_5555_5555_5555);
    send_item(ACT_INSERT, 64'hffff_ffff_ffff_fffe);
    send_item(ACT_INSERT, 64'h0000_0000_0000_0001);
    send_item(ACT_QUERY,  64'hffff_ffff_ffff_fffe);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
      end
    end
    cmd_valid = 1'b0;

    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (KEY_WIDTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== binary_trie_max_xor_search.f =====
rtl/core/btmx_pkg.sv
rtl/core/btmx_ram.sv
rtl/core/binary_trie_max_xor_search.sv
tb/sv/trie_answer_checker.sv
tb/sv/tb_binary_trie_max_xor_search.sv
